/* sv/lspsu_pkg.sv */
`timescale 1ns / 1ps
// Package for the louver stepper position sequencer: widths, mode codes,
// configuration indexes, shared structs and the coil pattern tables. No dependencies.
package lspsu_pkg;

  localparam int POS_W    = 12;
  localparam int STEP_W   = 8;
  localparam int HOLD_W   = 10;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DATA_W = 12;

  localparam logic [3:0] TEST_PRESCALE_LIMIT = 4'd8;
  localparam logic [3:0] TEST_DIVIDER_LIMIT  = 4'd15;
  localparam logic [2:0] NO_MODE             = 3'd7;

  typedef enum logic [2:0] {
    MODE_CLOSE   = 3'd0,
    MODE_OPEN    = 3'd1,
    MODE_DEFAULT = 3'd2,
    MODE_SWING   = 3'd3,
    MODE_RETURN  = 3'd4
  } mode_t;

  localparam logic [CFG_IDX_W-1:0] CFG_FULL_OPEN  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT    = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SWING_LOW  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SWING_HIGH = 4'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FAST_STEP  = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOW_STEP  = 4'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD       = 4'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_RETURN     = 4'd7;

  typedef struct packed {
    logic [POS_W-1:0]  full_open_position;
    logic [POS_W-1:0]  default_position;
    logic [POS_W-1:0]  swing_low_position;
    logic [POS_W-1:0]  swing_high_position;
    logic [STEP_W-1:0] fast_step_ticks;
    logic [STEP_W-1:0] slow_step_ticks;
    logic [HOLD_W-1:0] hold_ticks;
    logic              return_to_default;
  } cfg_t;

  typedef struct packed {
    logic [3:0]       coil_drive;
    logic [POS_W-1:0] current_position;
    logic [POS_W-1:0] target_position;
    logic [2:0]       mode;
  } result_t;

  // Half-step excitation sequence, bit0 A .. bit3 D.
  function automatic logic [3:0] half_step(input logic [2:0] idx);
    logic [3:0] pat;
    case (idx)
      3'd0:    pat = 4'h8;
      3'd1:    pat = 4'hc;
      3'd2:    pat = 4'h4;
      3'd3:    pat = 4'h6;
      3'd4:    pat = 4'h2;
      3'd5:    pat = 4'h3;
      3'd6:    pat = 4'h1;
      3'd7:    pat = 4'h9;
      default: pat = 4'h0;
    endcase
    return pat;
  endfunction

  // Single-coil self-test patterns.
  function automatic logic [3:0] test_pattern(input logic [2:0] idx);
    logic [3:0] pat;
    case (idx)
      3'd1:    pat = 4'h1;
      3'd2:    pat = 4'h2;
      3'd3:    pat = 4'h4;
      3'd4:    pat = 4'h8;
      default: pat = 4'h0;
    endcase
    return pat;
  endfunction

endpackage

/* sv/lspsu_in_if.sv */
`timescale 1ns / 1ps
// Tick input channel: valid/ready handshake with power, swing and self-test flags.
// Depends on nothing.
interface lspsu_in_if;
  logic valid;
  logic ready;
  logic power_on;
  logic swing_request;
  logic self_test;

  modport source (output valid, power_on, swing_request, self_test, input ready);
  modport sink   (input valid, power_on, swing_request, self_test, output ready);
endinterface

/* sv/lspsu_out_if.sv */
`timescale 1ns / 1ps
// Result channel: valid/ready handshake with coil levels, positions and mode.
// Depends on nothing.
interface lspsu_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  coil_drive;
  logic [11:0] current_position;
  logic [11:0] target_position;
  logic [2:0]  mode;

  modport source (output valid, coil_drive, current_position, target_position, mode,
                  input ready);
  modport sink   (input valid, coil_drive, current_position, target_position, mode,
                  output ready);
endinterface

/* sv/lspsu_cfg.sv */
`timescale 1ns / 1ps
// Configuration register file for the louver sequencer.
// Depends on lspsu_pkg.
module lspsu_cfg
  import lspsu_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.full_open_position  <= POS_W'(1500);
      cfg_r.default_position    <= POS_W'(1550);
      cfg_r.swing_low_position  <= POS_W'(1600);
      cfg_r.swing_high_position <= POS_W'(1650);
      cfg_r.fast_step_ticks     <= STEP_W'(2);
      cfg_r.slow_step_ticks     <= STEP_W'(10);
      cfg_r.hold_ticks          <= HOLD_W'(500);
      cfg_r.return_to_default   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FULL_OPEN:  cfg_r.full_open_position  <= cfg_wdata[POS_W-1:0];
        CFG_DEFAULT:    cfg_r.default_position    <= cfg_wdata[POS_W-1:0];
        CFG_SWING_LOW:  cfg_r.swing_low_position  <= cfg_wdata[POS_W-1:0];
        CFG_SWING_HIGH: cfg_r.swing_high_position <= cfg_wdata[POS_W-1:0];
        CFG_FAST_STEP:  cfg_r.fast_step_ticks     <= cfg_wdata[STEP_W-1:0];
        CFG_SLOW_STEP:  cfg_r.slow_step_ticks     <= cfg_wdata[STEP_W-1:0];
        CFG_HOLD:       cfg_r.hold_ticks          <= cfg_wdata[HOLD_W-1:0];
        CFG_RETURN:     cfg_r.return_to_default   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

/* sv/lspsu_core.sv */
`timescale 1ns / 1ps
// Sequencer state and per-tick next-state logic: timers, mode logic, motion and self test.
// Depends on lspsu_pkg.
module lspsu_core
  import lspsu_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  cfg_t    cfg,
  input  logic    tick,
  input  logic    power_on,
  input  logic    swing_request,
  input  logic    self_test,
  output result_t result
);

  mode_t             mode_r,     mode_nxt;
  logic [2:0]        entered_r,  entered_nxt;
  logic [POS_W-1:0]  pos_r,      pos_nxt;
  logic [POS_W-1:0]  tgt_r,      tgt_nxt;
  logic [STEP_W-1:0] period_r,   period_nxt;
  logic [2:0]        phase_r,    phase_nxt;
  logic [STEP_W-1:0] step_tmr_r, step_tmr_nxt;
  logic [HOLD_W-1:0] hold_tmr_r, hold_tmr_nxt;
  logic              resume_r,   resume_nxt;
  logic [3:0]        presc_r,    presc_nxt;
  logic [3:0]        div_r,      div_nxt;
  logic [3:0]        coil_r,     coil_nxt;

  always_comb begin
    logic       entering;
    logic [3:0] phase_sum;
    mode_nxt     = mode_r;
    entered_nxt  = entered_r;
    pos_nxt      = pos_r;
    tgt_nxt      = tgt_r;
    period_nxt   = period_r;
    phase_nxt    = phase_r;
    resume_nxt   = resume_r;
    div_nxt      = div_r;
    coil_nxt     = coil_r;
    entering     = 1'b0;
    phase_sum    = 4'd0;

    // Saturating tick timers.
    step_tmr_nxt = (step_tmr_r == '1) ? step_tmr_r : step_tmr_r + 1'b1;
    hold_tmr_nxt = (hold_tmr_r == '1) ? hold_tmr_r : hold_tmr_r + 1'b1;
    presc_nxt    = (presc_r == '1) ? presc_r : presc_r + 1'b1;

    if (self_test) begin
      if (presc_nxt >= TEST_PRESCALE_LIMIT) begin
        presc_nxt = 4'd0;
        div_nxt   = div_r + 1'b1;
        if (div_nxt >= TEST_DIVIDER_LIMIT) begin
          div_nxt   = 4'd0;
          phase_sum = {1'b0, phase_r} + 4'd1;
          phase_nxt = (phase_sum >= 4'd5) ? 3'd1 : phase_sum[2:0];
          coil_nxt  = test_pattern(phase_nxt);
        end
      end
    end else begin
      // Mode logic.
      if (!power_on) mode_nxt = MODE_CLOSE;
      entering = (entered_r != 3'(mode_nxt));
      if (entering) entered_nxt = 3'(mode_nxt);
      case (mode_nxt)
        MODE_CLOSE: begin
          if (entering) begin
            period_nxt = cfg.fast_step_ticks;
            pos_nxt    = cfg.full_open_position;
            tgt_nxt    = '0;
          end
          if (power_on) mode_nxt = MODE_OPEN;
        end
        MODE_OPEN: begin
          if (entering) begin
            period_nxt = cfg.fast_step_ticks;
            pos_nxt    = '0;
            tgt_nxt    = cfg.full_open_position;
          end
          if (pos_nxt == tgt_nxt) mode_nxt = MODE_DEFAULT;
        end
        MODE_DEFAULT: begin
          if (entering) begin
            period_nxt = cfg.fast_step_ticks;
            tgt_nxt    = cfg.default_position;
          end
          if (pos_nxt == tgt_nxt && swing_request) mode_nxt = MODE_SWING;
        end
        MODE_SWING: begin
          if (entering) begin
            period_nxt = cfg.slow_step_ticks;
            tgt_nxt    = cfg.swing_high_position;
          end
          if (pos_nxt == tgt_nxt) begin
            tgt_nxt = (pos_nxt == cfg.swing_low_position) ? cfg.swing_high_position
                                                          : cfg.swing_low_position;
          end
          if (cfg.return_to_default && !swing_request) mode_nxt = MODE_RETURN;
        end
        default: begin
          if (entering) begin
            period_nxt = cfg.fast_step_ticks;
            tgt_nxt    = cfg.default_position;
          end
          if (!cfg.return_to_default || swing_request) mode_nxt = MODE_SWING;
        end
      endcase

      // Motion stage.
      if (mode_nxt == MODE_SWING && !swing_request) begin
        hold_tmr_nxt = '0;
        coil_nxt     = 4'h0;
        resume_nxt   = 1'b1;
      end else if (mode_nxt == MODE_SWING && hold_tmr_nxt < cfg.hold_ticks && resume_r) begin
        coil_nxt = half_step(phase_r);
      end else begin
        resume_nxt = 1'b0;
        if (pos_nxt == tgt_nxt) begin
          hold_tmr_nxt = '0;
          coil_nxt     = 4'h0;
        end else if (step_tmr_nxt >= period_nxt) begin
          step_tmr_nxt = '0;
          if (hold_tmr_nxt < cfg.hold_ticks) begin
            coil_nxt = half_step(phase_r);
          end else begin
            hold_tmr_nxt = cfg.hold_ticks;
            if (tgt_nxt > pos_nxt) begin
              phase_nxt = phase_r - 3'd1;
              pos_nxt   = pos_nxt + 1'b1;
            end else begin
              phase_nxt = phase_r + 3'd1;
              pos_nxt   = pos_nxt - 1'b1;
            end
            coil_nxt = half_step(phase_nxt);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_CLOSE;
      entered_r  <= NO_MODE;
      pos_r      <= '0;
      tgt_r      <= '0;
      period_r   <= '0;
      phase_r    <= '0;
      step_tmr_r <= '0;
      hold_tmr_r <= '0;
      resume_r   <= 1'b0;
      presc_r    <= '0;
      div_r      <= '0;
      coil_r     <= '0;
    end else if (tick) begin
      mode_r     <= mode_nxt;
      entered_r  <= entered_nxt;
      pos_r      <= pos_nxt;
      tgt_r      <= tgt_nxt;
      period_r   <= period_nxt;
      phase_r    <= phase_nxt;
      step_tmr_r <= step_tmr_nxt;
      hold_tmr_r <= hold_tmr_nxt;
      resume_r   <= resume_nxt;
      presc_r    <= presc_nxt;
      div_r      <= div_nxt;
      coil_r     <= coil_nxt;
    end
  end

  // The transaction's result is the state it leaves behind.
  assign result.coil_drive       = coil_nxt;
  assign result.current_position = pos_nxt;
  assign result.target_position  = tgt_nxt;
  assign result.mode             = 3'(mode_nxt);

endmodule

/* sv/lspsu_obuf.sv */
`timescale 1ns / 1ps
// Two-entry result buffer: output register plus skid register.
// Depends on lspsu_pkg.
module lspsu_obuf
  import lspsu_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  result_t push_data,
  output logic    can_push,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  logic    main_valid_r;
  result_t main_data_r;
  logic    skid_valid_r;
  result_t skid_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!main_valid_r || out_ready) begin
      if (skid_valid_r) begin
        main_valid_r <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        main_valid_r <= push;
      end
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!main_valid_r || out_ready) begin
      main_data_r <= skid_valid_r ? skid_data_r : push_data;
    end else if (push) begin
      skid_data_r <= push_data;
    end
  end

  assign can_push  = !skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_data  = main_data_r;

endmodule

/* sv/louver_stepper_position_sequencer_unit.sv */
`timescale 1ns / 1ps
// Louver stepper position sequencer: one tick transaction in, one result transaction out.
// The result is registered in the output buffer; ticks stall while its skid is full.
// Throughput: one tick per cycle otherwise; the state update is a single registered pass.
// A two-entry output buffer keeps ticks flowing while one result waits to be taken.
// Reset (synchronous, rst_n low) restores all configuration defaults and clears state.
module louver_stepper_position_sequencer_unit
  import lspsu_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  lspsu_in_if.sink              in_ch,
  lspsu_out_if.source           out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t    cfg;
  result_t tick_result;
  result_t out_data;
  logic    can_push;
  logic    tick;

  // A tick is accepted whenever the skid register is free.
  assign in_ch.ready = can_push;
  assign tick        = in_ch.valid && can_push;

  // Configuration registers; users must write them only while idle; the block has no check.
  lspsu_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Mode, motion and self-test state, advanced once per accepted tick.
  lspsu_core u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .tick          (tick),
    .power_on      (in_ch.power_on),
    .swing_request (in_ch.swing_request),
    .self_test     (in_ch.self_test),
    .result        (tick_result)
  );

  // Result register with skid stage decouples the two sides.
  lspsu_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (tick),
    .push_data (tick_result),
    .can_push  (can_push),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_data)
  );

  assign out_ch.coil_drive       = out_data.coil_drive;
  assign out_ch.current_position = out_data.current_position;
  assign out_ch.target_position  = out_data.target_position;
  assign out_ch.mode             = out_data.mode;

  // The buffer only fills its skid entry while the output register is held.
  a_stall_means_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> out_ch.valid)
    else $error("input stalled while no result is pending");

  // A tick accepted into an empty buffer shows up on the next cycle.
  a_tick_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    (tick && !out_ch.valid) |=> out_ch.valid)
    else $error("accepted tick produced no result");

  // Only the five defined modes ever leave the block.
  a_mode_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.mode <= 3'd4))
    else $error("result carries an undefined mode code");

endmodule
